>>> rtl/mlmc_pkg.sv
// ----------------------------------------------------------------------------
// mlmc_pkg
// Shared types, constants and helper functions for the local-maxima counter.
// ----------------------------------------------------------------------------
package mlmc_pkg;

    localparam int DEF_MAX_COLS = 128;
    localparam int DEF_MAX_ROWS = 1024;

    localparam int PIX_W        = 16;
    localparam int PEAK_W       = 18;
    localparam int ROW_COUNT_W  = 11;
    localparam int COL_COUNT_W  = 8;
    localparam int CFG_DATA_W   = 11;
    localparam int CFG_IDX_W    = 1;
    localparam int LINE_W       = 2 * PIX_W;

    localparam int ROW_COUNT_RESET = 8;
    localparam int COL_COUNT_RESET = 8;

    // Neighbor offsets, row and column, in scan order.
    localparam int ROW_OFF [8] = '{-1, -1, -1, 0, 0, 1, 1, 1};
    localparam int COL_OFF [8] = '{-1, 0, 1, -1, 1, -1, 0, 1};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_COUNT = 1'b0,
        REG_COL_COUNT = 1'b1
    } cfg_reg_e;

    typedef logic signed [PIX_W-1:0] pix_t;

    // Window indexed [row][col]; row 0 is two rows up, col 0 two columns left.
    typedef logic [2:0][2:0][PIX_W-1:0] win3_t;

    typedef struct packed {
        logic row_ge1;
        logic row_ge2;
        logic col_ge1;
        logic col_ge2;
        logic last_row;
        logic last_col;
    } pos_flags_t;

    // Last valid index for a programmed size, clamped to 1..hi.
    function automatic int size_last(input int v, input int hi);
        int res;
        if (v < 1)
            res = 0;
        else if (v > hi)
            res = hi - 1;
        else
            res = v - 1;
        return res;
    endfunction

    // Strict local maximum at (cr, cc) against every neighbor inside the window
    // whose row and column are present.
    function automatic logic is_peak(input win3_t w, input int cr, input int cc,
                                     input logic [3:0] rv, input logic [3:0] cv);
        logic pk;
        int   nr;
        int   nc;
        pk = 1'b1;
        for (int k = 0; k < 8; k++)
        begin
            nr = cr + ROW_OFF[k];
            nc = cc + COL_OFF[k];
            if (nr >= 0 && nr <= 2 && nc >= 0 && nc <= 2)
            begin
                if (rv[nr] && cv[nc])
                begin
                    if ($signed(w[cr][cc]) <= $signed(w[nr][nc]))
                        pk = 1'b0;
                end
            end
        end
        return pk;
    endfunction

endpackage

>>> rtl/mlmc_if.sv
// ----------------------------------------------------------------------------
// mlmc interfaces
// Valid/ready channels for pixel input, result output and register writes.
// ----------------------------------------------------------------------------
interface mlmc_pix_if import mlmc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [PIX_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface mlmc_res_if import mlmc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [PEAK_W-1:0] peak_count;

    modport source (output valid, output peak_count, input ready);
    modport sink   (input valid, input peak_count, output ready);
endinterface

interface mlmc_cfg_if import mlmc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/matrix_local_maxima_count_core.sv
// ----------------------------------------------------------------------------
// matrix_local_maxima_count_core
// Streaming 3x3 strict local-maximum counter over a raster-order matrix.
// ----------------------------------------------------------------------------
// Usage:
//   pix  : one signed 16-bit element per word, raster order, row by row.
//   res  : one word per frame, the peak total, sent after the frame's last
//          element.
//   cfg  : register writes (index 0 row_count, index 1 col_count); a write
//          restarts the frame. Write only while the block is idle.
// Throughput: one element per cycle except in the stall below. An element
//   is registered on accept together with its column of the line store
//   (one RAM, registered read), then decided from those registers by a
//   single window compare stage. The result word is registered as the
//   frame's last element leaves the decide stage.
// Stall: a waiting result holds; the next frame's elements keep flowing
//   until the frame's last element reaches the decide stage, which then
//   waits for the result register to drain.
// Reset: sizes return to 8x8, position and count clear; the line store is
//   not cleared, its entries are only used once written in the frame.
// ----------------------------------------------------------------------------
module matrix_local_maxima_count_core import mlmc_pkg::*; #(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  logic      clk,
    input  logic      rst_n,
    mlmc_pix_if.sink  pix,
    mlmc_res_if.source res,
    mlmc_cfg_if.sink  cfg
);

    localparam int ColW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RowW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    logic [ColW-1:0]   col_last_reg;
    logic [RowW-1:0]   row_last_reg;
    logic [ColW-1:0]   col_pos_reg;
    logic [RowW-1:0]   row_pos_reg;

    logic              s1_valid_reg;
    pix_t              s1_value_reg;
    logic [ColW-1:0]   s1_col_reg;
    logic [RowW-1:0]   s1_row_reg;
    logic              s1_last_col_reg;
    logic              s1_last_row_reg;

    logic              fwd_reg;
    logic [LINE_W-1:0] fwd_data_reg;
    pix_t              win_reg [6];
    logic [PEAK_W-1:0] peaks_reg;
    logic [PEAK_W-1:0] peaks_next;
    logic              out_valid_reg;
    logic [PEAK_W-1:0] out_count_reg;

    logic              pix_fire;
    logic              cfg_fire;
    logic              s1_adv;
    logic              s1_frame_end;
    logic              at_last_col;
    logic              at_last_row;
    logic [LINE_W-1:0] ram_rd_data;
    logic [LINE_W-1:0] line_data;
    logic [LINE_W-1:0] wr_data;
    win3_t             win;
    pos_flags_t        flags;
    logic [2:0]        peak_cnt;

    assign pix_fire     = pix.valid & pix.ready;
    assign cfg_fire     = cfg.valid & cfg.ready;
    assign cfg.ready    = 1'b1;
    assign s1_frame_end = s1_last_row_reg & s1_last_col_reg;
    assign s1_adv       = s1_valid_reg & ~(s1_frame_end & out_valid_reg & ~res.ready);
    assign pix.ready    = ~s1_valid_reg | s1_adv;

    assign at_last_col = (col_pos_reg == col_last_reg);
    assign at_last_row = (row_pos_reg == row_last_reg);

    // Line store: upper row in the high half, middle row in the low half.
    assign line_data = fwd_reg ? fwd_data_reg : ram_rd_data;
    assign wr_data   = {line_data[PIX_W-1:0], s1_value_reg};

    mlmc_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_COLS)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (s1_adv),
        .wr_addr (s1_col_reg),
        .wr_data (wr_data),
        .rd_en   (pix_fire),
        .rd_addr (col_pos_reg),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            win[i][0] = win_reg[i * 2];
            win[i][1] = win_reg[i * 2 + 1];
        end
        win[0][2] = line_data[LINE_W-1:PIX_W];
        win[1][2] = line_data[PIX_W-1:0];
        win[2][2] = s1_value_reg;
    end

    assign flags.row_ge1  = (s1_row_reg != '0);
    assign flags.row_ge2  = (s1_row_reg > RowW'(1));
    assign flags.col_ge1  = (s1_col_reg != '0);
    assign flags.col_ge2  = (s1_col_reg > ColW'(1));
    assign flags.last_row = s1_last_row_reg;
    assign flags.last_col = s1_last_col_reg;

    mlmc_peak_eval u_peak_eval (
        .win   (win),
        .flags (flags),
        .cnt   (peak_cnt)
    );

    assign peaks_next = peaks_reg + PEAK_W'(peak_cnt);

    // Control and position state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_last_reg  <= ColW'(size_last(COL_COUNT_RESET, MAX_COLS));
            row_last_reg  <= RowW'(size_last(ROW_COUNT_RESET, MAX_ROWS));
            col_pos_reg   <= '0;
            row_pos_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            fwd_reg       <= 1'b0;
            peaks_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pix_fire)
            begin
                if (at_last_col)
                begin
                    col_pos_reg <= '0;
                    row_pos_reg <= at_last_row ? '0 : row_pos_reg + RowW'(1);
                end
                else
                begin
                    col_pos_reg <= col_pos_reg + ColW'(1);
                end
                // Read and write of the same column in one edge: forward the write.
                fwd_reg <= s1_adv && (s1_col_reg == col_pos_reg);
            end

            if (pix_fire)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;

            if (out_valid_reg && res.ready)
                out_valid_reg <= 1'b0;

            if (s1_adv)
            begin
                if (s1_frame_end)
                begin
                    out_valid_reg <= 1'b1;
                    peaks_reg     <= '0;
                end
                else
                begin
                    peaks_reg <= peaks_next;
                end
            end

            if (cfg_fire)
            begin
                case (cfg.index)
                    REG_ROW_COUNT:
                        row_last_reg <= RowW'(size_last(
                            int'(cfg.data[ROW_COUNT_W-1:0]), MAX_ROWS));
                    REG_COL_COUNT:
                        col_last_reg <= ColW'(size_last(
                            int'(cfg.data[COL_COUNT_W-1:0]), MAX_COLS));
                    default:
                        col_last_reg <= col_last_reg;
                endcase
                col_pos_reg <= '0;
                row_pos_reg <= '0;
                peaks_reg   <= '0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (pix_fire)
        begin
            s1_value_reg    <= pix.value;
            s1_col_reg      <= col_pos_reg;
            s1_row_reg      <= row_pos_reg;
            s1_last_col_reg <= at_last_col;
            s1_last_row_reg <= at_last_row;
            fwd_data_reg    <= wr_data;
        end
        if (s1_adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_reg[i * 2]     <= win[i][1];
                win_reg[i * 2 + 1] <= win[i][2];
            end
            if (s1_frame_end)
                out_count_reg <= peaks_next;
        end
    end

    assign res.valid      = out_valid_reg;
    assign res.peak_count = out_count_reg;

endmodule

>>> rtl/mlmc_ram.sv
// ----------------------------------------------------------------------------
// mlmc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mlmc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

endmodule

>>> rtl/mlmc_peak_eval.sv
// ----------------------------------------------------------------------------
// mlmc_peak_eval
// Decides up to four window centers and returns how many are peaks.
// ----------------------------------------------------------------------------
module mlmc_peak_eval import mlmc_pkg::*; (
    input  win3_t      win,
    input  pos_flags_t flags,
    output logic [2:0] cnt
);

    logic [3:0] rv;
    logic [3:0] cv;
    logic       p11;
    logic       p12;
    logic       p21;
    logic       p22;

    // Index 3 stands for the row below or the column to the right: never present.
    assign rv = {1'b0, 1'b1, flags.row_ge1, flags.row_ge2};
    assign cv = {1'b0, 1'b1, flags.col_ge1, flags.col_ge2};

    assign p11 = flags.row_ge1  & flags.col_ge1  & is_peak(win, 1, 1, rv, cv);
    assign p12 = flags.row_ge1  & flags.last_col & is_peak(win, 1, 2, rv, cv);
    assign p21 = flags.last_row & flags.col_ge1  & is_peak(win, 2, 1, rv, cv);
    assign p22 = flags.last_row & flags.last_col & is_peak(win, 2, 2, rv, cv);

    assign cnt = 3'(p11) + 3'(p12) + 3'(p21) + 3'(p22);

endmodule

>>> rtl/mlmc_checker.sv
// ----------------------------------------------------------------------------
// mlmc_checker
// Port-level checks on the local-maxima counter, bound to the top level.
// ----------------------------------------------------------------------------
module mlmc_checker import mlmc_pkg::*; (
    input logic              clk,
    input logic              rst_n,
    input logic              pix_valid,
    input logic              pix_ready,
    input logic              res_valid,
    input logic              res_ready,
    input logic [PEAK_W-1:0] res_peak_count
);

    // Hold a stalled result word.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result valid dropped while stalled");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_peak_count))
        else $error("result word changed while stalled");

    // A new result must be preceded by an accepted element.
    a_res_after_pix: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(pix_valid && pix_ready, 2))
        else $error("result appeared without a preceding element");

    // Input only backs up behind a waiting result.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> pix_ready)
        else $error("input stalled with empty result register");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_peak_count <= PEAK_W'(131072))
        else $error("peak count out of range");

endmodule

bind matrix_local_maxima_count_core mlmc_checker u_mlmc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .pix_valid      (pix.valid),
    .pix_ready      (pix.ready),
    .res_valid      (res.valid),
    .res_ready      (res.ready),
    .res_peak_count (res.peak_count)
);

>>> bench/matrix_local_maxima_count_core_test.sv
// ----------------------------------------------------------------------------
// matrix_local_maxima_count_core_test
// Streams signed matrices through the local-maxima counter and checks each
// frame's peak total against a cycle-free model of the 3x3 window. Covers the
// reset size, clamped and masked sizes, ties, rails, restarts on a size
// write, back-to-back frames, and a long result stall that backs up the input.
// ----------------------------------------------------------------------------
module matrix_local_maxima_count_core_test import mlmc_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD = 10;
    localparam int RESET_CYCLES = 8;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_ELEMENTS = 120;

    typedef enum int {
        SPREAD_FULL,
        SPREAD_NARROW,
        SPREAD_RAILS
    } spread_e;

    logic clk;
    logic rst_n;

    mlmc_pix_if pix_ch();
    mlmc_res_if res_ch();
    mlmc_cfg_if cfg_ch();

    matrix_local_maxima_count_core i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pix   (pix_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    pix_t              pending_elements[$];
    logic [PEAK_W-1:0] expected_totals[$];

    // Window model state
    logic [ROW_COUNT_W-1:0] row_setting = ROW_COUNT_RESET;
    logic [COL_COUNT_W-1:0] col_setting = COL_COUNT_RESET;
    pix_t                   two_up [DEF_MAX_COLS];
    pix_t                   one_up [DEF_MAX_COLS];
    pix_t                   win_hist [3][2];
    pix_t                   win_now [3][3];
    int                     col_at = 0;
    int                     row_at = 0;
    logic [PEAK_W-1:0]      peak_tally = '0;

    int fail_count = 0;
    int quiet_cycles = 0;
    int random_items = 0;
    bit calm = 1'b0;
    bit hold_armed = 1'b0;
    bit hold_taken = 1'b0;
    int hold_left = 0;

    always
    begin
        clk = 1'b0;
        #(HALF_PERIOD);
        clk = 1'b1;
        #(HALF_PERIOD);
    end

    function automatic int fit(input int v, input int hi);
        if (v < 1)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Strict maximum of win_now[cr][cc] over the neighbors whose row and
    // column are present in the frame.
    function automatic bit strict_max(input int cr, input int cc,
                                      input bit [3:0] rv, input bit [3:0] cv);
        int nr;
        int nc;
        bit keep;
        keep = 1'b1;
        for (int dr = -1; dr <= 1; dr++)
        begin
            for (int dc = -1; dc <= 1; dc++)
            begin
                nr = cr + dr;
                nc = cc + dc;
                if ((dr != 0 || dc != 0) && nr >= 0 && nr <= 2 && nc >= 0 && nc <= 2)
                begin
                    if (rv[nr] && cv[nc] && win_now[cr][cc] <= win_now[nr][nc])
                        keep = 1'b0;
                end
            end
        end
        return keep;
    endfunction

    task automatic take_element(input pix_t v);
        int rows;
        int cols;
        int r;
        int c;
        bit last_r;
        bit last_c;
        bit [3:0] rv;
        bit [3:0] cv;
        rows = fit(row_setting, DEF_MAX_ROWS);
        cols = fit(col_setting, DEF_MAX_COLS);
        r = row_at;
        c = col_at;
        if (c >= cols)
            c = 0;
        if (r >= rows)
            r = 0;
        last_r = (r == rows - 1);
        last_c = (c == cols - 1);
        for (int i = 0; i < 3; i++)
        begin
            win_now[i][0] = win_hist[i][0];
            win_now[i][1] = win_hist[i][1];
        end
        win_now[0][2] = two_up[c];
        win_now[1][2] = one_up[c];
        win_now[2][2] = v;
        // Bit 3 stands for the row below / column right: never present.
        rv = {1'b0, 1'b1, r >= 1, r >= 2};
        cv = {1'b0, 1'b1, c >= 1, c >= 2};
        if (r >= 1 && c >= 1)
            peak_tally += strict_max(1, 1, rv, cv);
        if (r >= 1 && last_c)
            peak_tally += strict_max(1, 2, rv, cv);
        if (last_r && c >= 1)
            peak_tally += strict_max(2, 1, rv, cv);
        if (last_r && last_c)
            peak_tally += strict_max(2, 2, rv, cv);
        two_up[c] = win_now[1][2];
        one_up[c] = v;
        for (int i = 0; i < 3; i++)
        begin
            win_hist[i][0] = win_now[i][1];
            win_hist[i][1] = win_now[i][2];
        end
        if (last_c)
        begin
            col_at = 0;
            if (last_r)
            begin
                expected_totals.push_back(peak_tally);
                peak_tally = '0;
                row_at = 0;
            end
            else
                row_at = r + 1;
        end
        else
        begin
            col_at = c + 1;
            row_at = r;
        end
    endtask

    function automatic pix_t pick_value(input spread_e spread);
        case (spread)
            SPREAD_FULL:
                return pix_t'($urandom);
            SPREAD_NARROW:
                return pix_t'(int'($urandom_range(0, 4)) - 2);
            default:
            begin
                case ($urandom_range(0, 4))
                    0: return pix_t'(-32768);
                    1: return pix_t'(32767);
                    2: return pix_t'(0);
                    3: return pix_t'(-1);
                    default: return pix_t'($urandom);
                endcase
            end
        endcase
    endfunction

    // Element source: present the next word once the current one is taken, with random idles unless calm.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_ch.valid <= 1'b0;
            pix_ch.value <= '0;
        end
        else if (!pix_ch.valid || pix_ch.ready)
        begin
            if (pending_elements.size() != 0 && (calm || $urandom_range(0, 99) >= 30))
            begin
                pix_ch.valid <= 1'b1;
                pix_ch.value <= pending_elements.pop_front();
            end
            else
                pix_ch.valid <= 1'b0;
        end
    end

    // Result sink, with one long hold-off when armed.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
        begin
            if (hold_armed && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= calm || ($urandom_range(0, 99) >= 30);
        end
    end

    // Monitor: predict on every accepted element, check every result word.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            quiet_cycles++;
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                quiet_cycles = 0;
                case (cfg_reg_e'(cfg_ch.index))
                    REG_ROW_COUNT: row_setting = cfg_ch.data[ROW_COUNT_W-1:0];
                    REG_COL_COUNT: col_setting = cfg_ch.data[COL_COUNT_W-1:0];
                    default: ;
                endcase
                // a size write restarts the frame
                col_at = 0;
                row_at = 0;
                peak_tally = '0;
            end
            if (pix_ch.valid && pix_ch.ready)
            begin
                quiet_cycles = 0;
                take_element(pix_ch.value);
            end
            if (res_ch.valid && res_ch.ready)
            begin
                quiet_cycles = 0;
                if (expected_totals.size() == 0)
                begin
                    $error("peak_count: unexpected word, got %0d", res_ch.peak_count);
                    fail_count++;
                end
                else if (res_ch.peak_count !== expected_totals[0])
                begin
                    $error("peak_count mismatch: expected %0d, got %0d",
                           expected_totals[0], res_ch.peak_count);
                    fail_count++;
                    void'(expected_totals.pop_front());
                end
                else
                    void'(expected_totals.pop_front());
            end
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Wait until every element is taken and every total has come back.
    task automatic settle();
        do
            @(negedge clk);
        while (pending_elements.size() != 0 || pix_ch.valid || expected_totals.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(input cfg_reg_e idx, input int data);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= CFG_DATA_W'(data);
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic program_size(input int row_req, input int col_req);
        write_register(REG_ROW_COUNT, row_req);
        write_register(REG_COL_COUNT, col_req);
        @(negedge clk);
    endtask

    task automatic run_phase(input int row_req, input int col_req, input int frames,
                             input spread_e spread);
        int cells;
        program_size(row_req, col_req);
        cells = fit(row_req & 'h7FF, DEF_MAX_ROWS) * fit(col_req & 'hFF, DEF_MAX_COLS);
        for (int f = 0; f < frames; f++)
        begin
            for (int k = 0; k < cells; k++)
                pending_elements.push_back(pick_value(spread));
        end
        random_items += cells * frames;
        settle();
    endtask

    initial
    begin
        int rows;
        int cols;
        rst_n <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= REG_ROW_COUNT;
        cfg_ch.data <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset size, no write yet.
        for (int k = 0; k < ROW_COUNT_RESET * COL_COUNT_RESET; k++)
            pending_elements.push_back(pick_value(SPREAD_RAILS));
        settle();

        // Zero sizes act as 1x1: every lone element is a peak.
        program_size(0, 0);
        pending_elements.push_back(pix_t'(-32768));
        pending_elements.push_back(pix_t'(32767));
        pending_elements.push_back(pix_t'(0));
        settle();

        // Single row: a tie yields nothing, a lone rail wins.
        program_size(1, 3);
        pending_elements = '{pix_t'(5), pix_t'(5), pix_t'(5),
                             pix_t'(-32768), pix_t'(32767), pix_t'(-32768)};
        settle();

        program_size(2, 2);
        pending_elements = '{pix_t'(7), pix_t'(7), pix_t'(7), pix_t'(8),
                             pix_t'(1), pix_t'(2), pix_t'(3), pix_t'(4)};
        settle();

        // Drop a partial frame; the size write below restarts the raster.
        program_size(3, 3);
        pending_elements = '{pix_t'(1), pix_t'(2), pix_t'(3), pix_t'(4)};
        settle();
        program_size(3, 3);
        for (int k = 0; k < 9; k++)
            pending_elements.push_back(k == 4 ? pix_t'(32767) : pix_t'(-32768));
        settle();

        // Column write with bits above the register width: masked to 5.
        program_size(1, 'h105);
        pending_elements = '{pix_t'(0), pix_t'(-1), pix_t'(32767), pix_t'(-1), pix_t'(0)};
        settle();

        // Column size clamped at the store depth.
        run_phase(2, 255, 1, SPREAD_RAILS);

        // Back-to-back frames with no idling on either side.
        calm = 1'b1;
        run_phase(4, 8, 4, SPREAD_FULL);
        calm = 1'b0;

        // Hold the result side off while small frames keep coming.
        program_size(2, 2);
        hold_armed = 1'b1;
        for (int k = 0; k < 48; k++)
            pending_elements.push_back(pick_value(SPREAD_NARROW));
        settle();

        random_items = 0;
        while (random_items < RANDOM_ELEMENTS)
        begin
            rows = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 5);
            cols = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
            run_phase(rows, cols, $urandom_range(1, 2), spread_e'($urandom_range(0, 2)));
        end

        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> matrix_local_maxima_count_core.f
rtl/mlmc_pkg.sv
rtl/mlmc_if.sv
rtl/mlmc_ram.sv
rtl/mlmc_peak_eval.sv
rtl/matrix_local_maxima_count_core.sv
rtl/mlmc_checker.sv
bench/matrix_local_maxima_count_core_test.sv
